// ===== rtl/blist_pkg.sv =====
// Shared types and constants for the bounded list unit.
package blist_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int MODE_W       = 2;
    localparam int POS_W        = 5;
    localparam int COUNT_W      = 5;
    localparam int GRP_SIZE     = 8;

    localparam logic [MODE_W-1:0] MODE_APPEND  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PREPEND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FIND    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_REMOVE  = 2'd3;

    typedef enum logic [2:0] {
        ACT_HOLD,
        ACT_APPEND,
        ACT_PREPEND,
        ACT_REMOVE,
        ACT_COMPARE
    } cell_act_t;

    typedef struct packed {
        cell_act_t                  act;
        logic signed [VALUE_W-1:0]  value;
    } cell_cmd_t;

endpackage

// ===== rtl/blist_in_if.sv =====
// Request channel: operation mode and value.
interface blist_in_if;
    import blist_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [MODE_W-1:0]          mode;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

// ===== rtl/blist_out_if.sv =====
// Result channel: position, entry count and refusal flag.
interface blist_out_if;
    import blist_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  position;
    logic [COUNT_W-1:0]       entry_count;
    logic                     full_refused;

    modport source (output valid, output position, output entry_count,
                    output full_refused, input ready);
    modport sink   (input valid, input position, input entry_count,
                    input full_refused, output ready);
endinterface

// ===== rtl/bounded_list_insert_find_remove_unit.sv =====
// Bounded ordered list: append, prepend, find and remove over a row of cells.
// A result loads only once the output register is free. Append/prepend load it
//   from the insert state; find/remove run a parallel compare in every cell, then
//   a scan of NGRP = ceil(CAPACITY/8) groups, 8 cells per cycle, to the first hit.
// Throughput: one request at a time; the next is taken the cycle after the result
//   word is registered, even while that word still waits on rsp.ready.
// Reset: count and control clear at once; cell entries have no reset.
module bounded_list_insert_find_remove_unit #(
    parameter int CAPACITY = blist_pkg::CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    blist_in_if.sink    req,
    blist_out_if.source rsp
);
    import blist_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int NGRP  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int OFF_W = $clog2(GRP_SIZE);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_CMP,
        S_SCAN
    } state_t;

    state_t                     state_reg;
    logic [MODE_W-1:0]          mode_reg;
    logic signed [VALUE_W-1:0]  value_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [GRP_W-1:0]           grp_reg;

    logic                       out_valid_reg;
    logic signed [POS_W-1:0]    out_pos_reg;
    logic [COUNT_W-1:0]         out_count_reg;
    logic                       out_full_reg;

    // cell row
    cell_cmd_t                  cmd;
    logic signed [VALUE_W-1:0]  cell_data [CAPACITY];
    logic [CAPACITY-1:0]        hits;
    logic [IDX_W-1:0]           at_idx;

    // scan of registered match bits, one group of 8 cells per cycle until a hit
    logic [NGRP*GRP_SIZE-1:0]   hit_pad;
    logic [GRP_SIZE-1:0]        grp_hits;
    logic [OFF_W-1:0]           off;
    logic                       grp_any;
    logic                       grp_last;
    logic                       out_free;
    logic                       out_load;
    logic                       is_full;

    assign out_free = !out_valid_reg || rsp.ready;
    assign is_full  = count_reg >= CNT_W'(CAPACITY);
    assign grp_last = grp_reg == GRP_W'(NGRP - 1);

    // a result word is registered this cycle
    assign out_load = out_free && ((state_reg == S_INS)
                                   || (state_reg == S_SCAN && (grp_any || grp_last)));

    always_comb
    begin
        hit_pad                 = '0;
        hit_pad[CAPACITY-1:0]   = hits;
        grp_hits                = hit_pad[grp_reg*GRP_SIZE +: GRP_SIZE];
        grp_any                 = |grp_hits;
        off                     = '0;
        for (int i = GRP_SIZE - 1; i >= 0; i--)
        begin
            if (grp_hits[i])
            begin
                off = OFF_W'(i);
            end
        end
        at_idx = IDX_W'({grp_reg, off});
    end

    // command broadcast to every cell
    always_comb
    begin
        cmd.act   = ACT_HOLD;
        cmd.value = value_reg;
        case (state_reg)
            S_INS:
            begin
                if (out_free && !is_full)
                begin
                    cmd.act = (mode_reg == MODE_APPEND) ? ACT_APPEND : ACT_PREPEND;
                end
            end
            S_CMP:
            begin
                cmd.act = ACT_COMPARE;
            end
            S_SCAN:
            begin
                if (out_free && grp_any && mode_reg == MODE_REMOVE)
                begin
                    cmd.act = ACT_REMOVE;
                end
            end
            default:
            begin
            end
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        blist_cell #(
            .IDX   (g),
            .CNT_W (CNT_W),
            .IDX_W (IDX_W)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .count      (count_reg),
            .at         (at_idx),
            .left_data  (cell_data[(g > 0) ? g - 1 : g]),
            .right_data (cell_data[(g < CAPACITY - 1) ? g + 1 : g]),
            .data       (cell_data[g]),
            .hit        (hits[g])
        );
    end

    // sequencer with count and result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            grp_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // new word loads, otherwise the held one clears once taken
            out_valid_reg <= out_load || (out_valid_reg && !rsp.ready);
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        mode_reg  <= req.mode;
                        value_reg <= req.value;
                        grp_reg   <= '0;
                        if (req.mode inside {MODE_APPEND, MODE_PREPEND})
                        begin
                            state_reg <= S_INS;
                        end
                        else
                        begin
                            state_reg <= S_CMP;
                        end
                    end
                end
                S_INS:
                begin
                    if (out_free)
                    begin
                        state_reg     <= S_IDLE;
                        if (is_full)
                        begin
                            out_pos_reg   <= '1;
                            out_count_reg <= COUNT_W'(count_reg);
                            out_full_reg  <= 1'b1;
                        end
                        else
                        begin
                            out_pos_reg   <= (mode_reg == MODE_APPEND)
                                             ? POS_W'(count_reg) : '0;
                            out_count_reg <= COUNT_W'(count_reg + 1'b1);
                            out_full_reg  <= 1'b0;
                            count_reg     <= count_reg + 1'b1;
                        end
                    end
                end
                S_CMP:
                begin
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (grp_any || grp_last)
                    begin
                        if (out_free)
                        begin
                            out_full_reg  <= 1'b0;
                            state_reg     <= S_IDLE;
                            if (grp_any)
                            begin
                                out_pos_reg <= POS_W'(at_idx);
                                if (mode_reg == MODE_REMOVE)
                                begin
                                    count_reg     <= count_reg - 1'b1;
                                    out_count_reg <= COUNT_W'(count_reg - 1'b1);
                                end
                                else
                                begin
                                    out_count_reg <= COUNT_W'(count_reg);
                                end
                            end
                            else
                            begin
                                out_pos_reg   <= '1;
                                out_count_reg <= COUNT_W'(count_reg);
                            end
                        end
                    end
                    else
                    begin
                        grp_reg <= grp_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req.ready        = state_reg == S_IDLE;
    assign rsp.valid        = out_valid_reg;
    assign rsp.position     = out_pos_reg;
    assign rsp.entry_count  = out_count_reg;
    assign rsp.full_refused = out_full_reg;

    // count stays within capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("count above capacity");

    // count moves by at most one per cycle
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (count_reg == $past(count_reg))
              || (count_reg == $past(count_reg) + 1'b1)
              || (count_reg == $past(count_reg) - 1'b1))
        else $error("count jumped");

    // a refused insert reports not-found and a full list
    a_refused: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.full_refused
        |-> (rsp.position == '1) && (rsp.entry_count == COUNT_W'(CAPACITY)))
        else $error("bad refused word");

    // a taken request is in work in the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg != S_IDLE)
        else $error("request dropped");

    // the scan never runs past the last group
    a_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> grp_reg <= GRP_W'(NGRP - 1))
        else $error("scan overrun");

endmodule

// ===== rtl/blist_cell.sv =====
// One list cell: holds an entry, compares it, shifts with its neighbors.
module blist_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5,
    parameter int IDX_W = 4
) (
    input  logic                               clk,
    input  blist_pkg::cell_cmd_t               cmd,
    input  logic [CNT_W-1:0]                   count,
    input  logic [IDX_W-1:0]                   at,
    input  logic signed [blist_pkg::VALUE_W-1:0] left_data,
    input  logic signed [blist_pkg::VALUE_W-1:0] right_data,
    output logic signed [blist_pkg::VALUE_W-1:0] data,
    output logic                               hit
);
    import blist_pkg::*;

    logic signed [VALUE_W-1:0] data_reg;
    logic                      hit_reg;
    logic                      below_count;

    assign below_count = CNT_W'(IDX) < count;

    always_ff @(posedge clk)
    begin
        case (cmd.act)
            ACT_APPEND:
            begin
                if (CNT_W'(IDX) == count)
                begin
                    data_reg <= cmd.value;
                end
            end
            ACT_PREPEND:
            begin
                if (IDX == 0)
                begin
                    data_reg <= cmd.value;
                end
                else if (CNT_W'(IDX) <= count)
                begin
                    data_reg <= left_data;
                end
            end
            ACT_REMOVE:
            begin
                // entries above the count pick up junk, never read
                if (IDX_W'(IDX) >= at)
                begin
                    data_reg <= right_data;
                end
            end
            ACT_COMPARE:
            begin
                hit_reg <= below_count && (data_reg == cmd.value);
            end
            default:
            begin
            end
        endcase
    end

    assign data = data_reg;
    assign hit  = hit_reg;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the bounded ordered list unit.
module tb_top;
    import blist_pkg::*;

    localparam int CAP          = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 500;
    localparam int IDLE_LIMIT   = 2000;   // cycles with no word moving on either channel
    localparam int END_SETTLE   = 16;     // cycles waited after the last answer before the verdict

    localparam logic signed [POS_W-1:0]   POS_NONE = -1;
    localparam logic signed [VALUE_W-1:0] VAL_MIN  = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VAL_ZERO = 32'sh0000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_NEG1 = 32'shFFFF_FFFF;

    // One request word plus a flag that holds it back until the unit has
    // answered everything in flight.
    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [VALUE_W-1:0] value;
        logic                      wait_drain;
    } list_req_t;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic [COUNT_W-1:0]      entry_count;
        logic                    full_refused;
    } list_ans_t;

    logic clk;
    logic rst_n;

    blist_in_if  req_if ();
    blist_out_if rsp_if ();

    bounded_list_insert_find_remove_unit #(.CAPACITY(CAP)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Shadow copy of the list contents; only slots below list_len are ever read.
    logic signed [VALUE_W-1:0] list_slots [CAP];
    int                        list_len;

    list_req_t request_backlog  [$];
    list_ans_t expected_answers [$];

    int  total_requests;
    int  accepted_requests;
    int  mismatch_count;
    int  idle_cycles;
    bit  req_taken;

    // Sender burst/gap counters and receiver stall pattern state.
    int  burst_left;
    int  gap_left;
    int  ready_style;
    int  ready_phase_left;
    int  stall_left;

    // Value pool: mostly repeats so that find/remove hit, plus the extremes.
    logic signed [VALUE_W-1:0] value_pool [10];

    // ------------------------------------------------------------------
    // Predictor: apply one operation to the shadow list, return the answer.
    // ------------------------------------------------------------------
    function automatic list_ans_t list_apply(input list_req_t r);
        list_ans_t a;
        int        hit;
        a.position     = POS_NONE;
        a.full_refused = 1'b0;
        hit            = -1;
        case (r.mode)
            MODE_APPEND, MODE_PREPEND:
            begin
                if (list_len >= CAP)
                begin
                    // full: list untouched, refusal flagged
                    a.full_refused = 1'b1;
                end
                else if (r.mode == MODE_APPEND)
                begin
                    list_slots[list_len] = r.value;
                    a.position           = list_len[POS_W-1:0];
                    list_len++;
                end
                else
                begin
                    for (int i = list_len; i > 0; i--)
                        list_slots[i] = list_slots[i-1];
                    list_slots[0] = r.value;
                    a.position    = '0;
                    list_len++;
                end
            end
            default:
            begin
                // find and remove both act on the lowest matching slot
                for (int i = 0; i < list_len; i++)
                    if (hit < 0 && list_slots[i] == r.value)
                        hit = i;
                if (hit >= 0)
                begin
                    a.position = hit[POS_W-1:0];
                    if (r.mode == MODE_REMOVE)
                    begin
                        for (int i = hit; i + 1 < list_len; i++)
                            list_slots[i] = list_slots[i+1];
                        list_len--;
                    end
                end
            end
        endcase
        a.entry_count = list_len[COUNT_W-1:0];
        return a;
    endfunction

    task automatic queue_request(input logic [MODE_W-1:0] m,
                                 input logic signed [VALUE_W-1:0] v,
                                 input bit drain);
        list_req_t r;
        r.mode       = m;
        r.value      = v;
        r.wait_drain = drain;
        request_backlog.push_back(r);
        total_requests++;
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 9) < 7)
            return value_pool[$urandom_range(0, 9)];
        return $urandom;
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Driver: inputs change on the falling edge. A word stays on the bus
    // until the rising edge that takes it; the next word (or idle) is put
    // up on the following falling edge.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : driver
        list_req_t next_req;
        if (rst_n && (!req_if.valid || req_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                req_if.valid <= 1'b0;
            end
            else if (request_backlog.size() > 0 &&
                     !(request_backlog[0].wait_drain && expected_answers.size() != 0))
            begin
                next_req = request_backlog.pop_front();
                req_if.valid <= 1'b1;
                req_if.mode  <= next_req.mode;
                req_if.value <= next_req.value;
                burst_left--;
                if (burst_left <= 0)
                begin
                    // new burst; about a third of bursts run back to back
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else
            begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver ready pattern: switches between always-ready, coin-flip and
    // long-stall styles, each held for a phase of random length.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : ready_pattern
        logic rdy;
        if (ready_phase_left == 0)
        begin
            ready_style      = $urandom_range(0, 2);
            ready_phase_left = $urandom_range(20, 120);
        end
        else
        begin
            ready_phase_left--;
        end
        case (ready_style)
            0: rdy = 1'b1;
            1: rdy = 1'($urandom_range(0, 1));
            default:
            begin
                if (stall_left > 0)
                begin
                    stall_left--;
                    rdy = 1'b0;
                end
                else if ($urandom_range(0, 5) == 0)
                begin
                    stall_left = $urandom_range(3, 14);
                    rdy        = 1'b0;
                end
                else
                begin
                    rdy = 1'b1;
                end
            end
        endcase
        rsp_if.ready <= rdy;
    end

    // ------------------------------------------------------------------
    // Monitor: sample both channels on the rising edge. Result words are
    // checked against the oldest prediction; taken request words are run
    // through the predictor.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        list_ans_t got;
        list_ans_t want;
        list_req_t seen;
        if (rst_n)
        begin
            req_taken <= req_if.valid && req_if.ready;

            if (rsp_if.valid && rsp_if.ready)
            begin
                got.position     = rsp_if.position;
                got.entry_count  = rsp_if.entry_count;
                got.full_refused = rsp_if.full_refused;
                if (expected_answers.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: unexpected result word pos=%0d count=%0d refused=%0b",
                                 got.position, got.entry_count, got.full_refused);
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (got.position !== want.position ||
                        got.entry_count !== want.entry_count ||
                        got.full_refused !== want.full_refused)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("ERROR: result mismatch: expected pos=%0d count=%0d ",
                                     want.position, want.entry_count,
                                     "refused=%0b, got pos=%0d count=%0d refused=%0b",
                                     want.full_refused,
                                     got.position, got.entry_count, got.full_refused);
                    end
                end
            end

            if (req_if.valid && req_if.ready)
            begin
                seen.mode       = req_if.mode;
                seen.value      = req_if.value;
                seen.wait_drain = 1'b0;
                expected_answers.push_back(list_apply(seen));
                accepted_requests++;
            end

            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin : main
        int  phase_left;
        int  grow_bias;
        int  pick;
        bit  timed_out;

        rst_n             = 1'b0;
        req_if.valid      = 1'b0;
        req_if.mode       = MODE_APPEND;
        req_if.value      = '0;
        rsp_if.ready      = 1'b0;
        list_len          = 0;
        total_requests    = 0;
        accepted_requests = 0;
        mismatch_count    = 0;
        idle_cycles       = 0;
        req_taken         = 1'b0;
        burst_left        = $urandom_range(1, 40);
        gap_left          = 0;
        ready_style       = 0;
        ready_phase_left  = 0;
        stall_left        = 0;
        timed_out         = 1'b0;

        value_pool[0] = VAL_MIN;
        value_pool[1] = VAL_MAX;
        value_pool[2] = VAL_ZERO;
        value_pool[3] = VAL_NEG1;
        for (int i = 4; i < 10; i++)
            value_pool[i] = $urandom;

        // Directed: empty-list lookups, extremes, duplicates, fill to full,
        // refused inserts, then a find and remove on a full list.
        queue_request(MODE_FIND,    VAL_ZERO, 1'b0);   // find on empty
        queue_request(MODE_REMOVE,  VAL_ZERO, 1'b0);   // remove on empty
        queue_request(MODE_APPEND,  VAL_MIN,  1'b0);
        queue_request(MODE_PREPEND, VAL_MAX,  1'b0);
        queue_request(MODE_APPEND,  VAL_NEG1, 1'b0);
        queue_request(MODE_APPEND,  VAL_MIN,  1'b0);   // duplicate
        queue_request(MODE_FIND,    VAL_MIN,  1'b0);   // lowest of two
        queue_request(MODE_REMOVE,  VAL_MIN,  1'b0);   // removes the lower one
        queue_request(MODE_FIND,    VAL_MIN,  1'b0);   // the other copy now
        queue_request(MODE_REMOVE,  VAL_ZERO, 1'b0);   // absent
        for (int i = 0; i < CAP - 3; i++)
            queue_request((i % 2 == 0) ? MODE_PREPEND : MODE_APPEND, $urandom, 1'b0);
        queue_request(MODE_APPEND,  VAL_ZERO, 1'b0);   // refused, full
        queue_request(MODE_PREPEND, VAL_ZERO, 1'b0);   // refused, full
        queue_request(MODE_FIND,    VAL_MAX,  1'b0);
        queue_request(MODE_REMOVE,  VAL_MAX,  1'b0);

        // Random: phases that lean toward growing or shrinking so the count
        // sweeps between empty and full. The first random word waits for
        // the pipe to drain, and so does about one in fifty after it.
        phase_left = 0;
        grow_bias  = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(20, 60);
                grow_bias  = $urandom_range(20, 80);
            end
            phase_left--;
            pick = $urandom_range(0, 99);
            if (pick < grow_bias)
                queue_request($urandom_range(0, 1) ? MODE_PREPEND : MODE_APPEND,
                              pick_value(), n == 0 || $urandom_range(0, 49) == 0);
            else
                queue_request($urandom_range(0, 2) == 0 ? MODE_FIND : MODE_REMOVE,
                              pick_value(), n == 0 || $urandom_range(0, 49) == 0);
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for every word to be taken and answered; checked on the
        // falling edge, where the monitor's counters are settled.
        while (!(accepted_requests == total_requests && expected_answers.size() == 0))
        begin
            @(negedge clk);
            if (idle_cycles >= IDLE_LIMIT)
            begin
                timed_out = 1'b1;
                break;
            end
        end

        if (timed_out)
        begin
            $display("ERROR: no word moved for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
        end
        else
        begin
            // extra result words would show up here as unexpected
            repeat (END_SETTLE) @(negedge clk);
            if (mismatch_count == 0 && expected_answers.size() == 0)
                $display("*** PASSED ***");
            else
                $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/blist_pkg.sv
rtl/blist_in_if.sv
rtl/blist_out_if.sv
rtl/blist_cell.sv
rtl/bounded_list_insert_find_remove_unit.sv
tb/tb_top.sv
